// ===== rtl/core/ssc_pkg.sv =====
// Shared constants, item kind codes and controller/datapath interface types.
package ssc_pkg;

	// Ring geometry
	localparam int BUFFER_DEPTH = 16;
	localparam int PTR_W        = $clog2(BUFFER_DEPTH);
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

	// Stream and register widths
	localparam int KIND_W     = 3;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 216;
	localparam int OUT_USER_W = 2;
	localparam int GAIN_W     = 24;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd627733;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DONE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BUSERR = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_START  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_STOP   = 3'd5;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd6;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic in_ready;
		logic capture;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/core/sensor_sample_capture_fifo_core.sv =====
// Flow: an accepted input item passes the execute and commit states before its result
//   item is registered; items are taken one at a time (capture, multiply/ring read, commit),
//   and commit waits while a finished result waits in the output register.
// Reset: arst_n clears sampling, pending read, pointers, fill count and counters
//   and loads the gain register with 627733; ring contents are not cleared.
// Top level of the sensor sample capture ring buffer.
module sensor_sample_capture_fifo_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// from bit 0: launch_ok, byte0, byte1, byte2, byte3, byte4, byte5, now_ms, zero pad
	input  logic [ssc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic [ssc_pkg::KIND_W-1:0]     s_axis_tuser,
	input  logic                           cfg_we,
	input  logic [ssc_pkg::GAIN_W-1:0]     cfg_wdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// from bit 0: out_x, out_y, out_z, out_time, fill_level, samples_total,
	// bus_errors, overruns, latest_time, zero pad
	output logic [ssc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// from bit 0: start_read, sample_valid
	output logic [ssc_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import ssc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequence items
	ssc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.status        (status),
		.cmd           (cmd)
	);

	// Process items
	ssc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	assign s_axis_tready = cmd.in_ready;

endmodule

// ===== rtl/core/ssc_ctrl.sv =====
// Controller state machine: sequences capture, execute and commit of one item.
module ssc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	input  ssc_pkg::dp_status_t status,
	output ssc_pkg::ctrl_cmd_t  cmd
);
	import ssc_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Decode commands
	always_comb begin
		cmd.in_ready = (state_q == ST_IDLE);
		cmd.capture  = (state_q == ST_IDLE) && s_axis_tvalid;
		cmd.commit   = (state_q == ST_COMMIT) && status.out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/ssc_datapath.sv =====
// Datapath: item capture, axis scaling, sample ring, statistics and output register.
module ssc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ssc_pkg::ctrl_cmd_t                cmd,
	output ssc_pkg::dp_status_t               status,
	input  logic [ssc_pkg::KIND_W-1:0]        s_axis_tuser,
	input  logic [ssc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  logic                              cfg_we,
	input  logic [ssc_pkg::GAIN_W-1:0]        cfg_wdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [ssc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic [ssc_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
	import ssc_pkg::*;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

	// Captured item
	logic [KIND_W-1:0] kind_s1;
	logic              launch_s1;
	logic [15:0]       raw_x_s1;
	logic [15:0]       raw_y_s1;
	logic [15:0]       raw_z_s1;
	logic [31:0]       now_s1;

	// Scaling products
	logic signed [40:0] prod_x_s2;
	logic signed [40:0] prod_y_s2;
	logic signed [40:0] prod_z_s2;

	// Ring storage: {time, z, y, x}
	logic [79:0] ring_mem [BUFFER_DEPTH];
	logic [79:0] rd_data_q;

	// Control state
	logic [GAIN_W-1:0] gain_q;
	logic              sampling_q;
	logic              pending_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [31:0]       total_q;
	logic [31:0]       err_q;
	logic [31:0]       ovr_q;
	logic [31:0]       last_q;
	logic              m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [OUT_USER_W-1:0] m_user_q;

	// Next values at commit
	logic              sampling_d;
	logic              pending_d;
	logic [PTR_W-1:0]  head_d;
	logic [PTR_W-1:0]  tail_d;
	logic [CNT_W-1:0]  count_d;
	logic [31:0]       total_d;
	logic [31:0]       err_d;
	logic [31:0]       ovr_d;
	logic [31:0]       last_d;
	logic              wr_en;
	logic              start_rd;
	logic              valid_rd;
	logic [79:0]       pop_word;
	logic [15:0]       sat_x;
	logic [15:0]       sat_y;
	logic [15:0]       sat_z;

	function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] i);
		return (i == PTR_LAST) ? '0 : i + PTR_W'(1);
	endfunction

	// Floor shift by 20 and clamp to signed 16 bits
	function automatic logic [15:0] sat_q12(input logic signed [40:0] p);
		logic [20:0] q;
		q = p[40:20];
		if (q[20:15] == 6'b000000 || q[20:15] == 6'b111111) return q[15:0];
		return q[20] ? 16'h8000 : 16'h7FFF;
	endfunction

	assign status.out_free = !m_valid_q || m_axis_tready;

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_s1   <= s_axis_tuser;
			launch_s1 <= s_axis_tdata[0];
			raw_x_s1  <= {s_axis_tdata[16:9], s_axis_tdata[8:1]};
			raw_y_s1  <= {s_axis_tdata[32:25], s_axis_tdata[24:17]};
			raw_z_s1  <= {s_axis_tdata[48:41], s_axis_tdata[40:33]};
			now_s1    <= s_axis_tdata[80:49];
		end
	end

	// Scale each axis by the gain
	always_ff @(posedge clk) begin
		prod_x_s2 <= $signed(raw_x_s1) * $signed({1'b0, gain_q});
		prod_y_s2 <= $signed(raw_y_s1) * $signed({1'b0, gain_q});
		prod_z_s2 <= $signed(raw_z_s1) * $signed({1'b0, gain_q});
	end

	assign sat_x = sat_q12(prod_x_s2);
	assign sat_y = sat_q12(prod_y_s2);
	assign sat_z = sat_q12(prod_z_s2);

	// Ring write at head, registered read at tail
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			ring_mem[head_q] <= {now_s1, sat_z, sat_y, sat_x};
		end
		rd_data_q <= ring_mem[tail_q];
	end

	// Work out the item's effect
	always_comb begin
		sampling_d = sampling_q;
		pending_d  = pending_q;
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		total_d    = total_q;
		err_d      = err_q;
		ovr_d      = ovr_q;
		last_d     = last_q;
		wr_en      = 1'b0;
		start_rd   = 1'b0;
		valid_rd   = 1'b0;
		pop_word   = '0;
		unique case (kind_s1)
			KIND_TICK: begin
				if (sampling_q && !pending_q) begin
					if (launch_s1) begin
						pending_d = 1'b1;
						start_rd  = 1'b1;
					end else begin
						err_d = err_q + 32'd1;
					end
				end
			end
			KIND_DONE: begin
				pending_d = 1'b0;
				if (count_q == CNT_FULL) begin
					tail_d = next_idx(tail_q);
					ovr_d  = ovr_q + 32'd1;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
				wr_en   = 1'b1;
				head_d  = next_idx(head_q);
				total_d = total_q + 32'd1;
				last_d  = now_s1;
			end
			KIND_BUSERR: begin
				pending_d = 1'b0;
				err_d     = err_q + 32'd1;
			end
			KIND_POP: begin
				if (count_q != '0) begin
					valid_rd = 1'b1;
					pop_word = rd_data_q;
					tail_d   = next_idx(tail_q);
					count_d  = count_q - CNT_W'(1);
				end
			end
			KIND_START: begin
				if (!sampling_q) begin
					sampling_d = 1'b1;
					pending_d  = 1'b0;
				end
			end
			KIND_STOP: begin
				sampling_d = 1'b0;
			end
			KIND_CLEAR: begin
				total_d = '0;
				err_d   = '0;
				ovr_d   = '0;
				last_d  = '0;
			end
			default: begin
			end
		endcase
	end

	// Update state on commit, hold the gain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= GAIN_RESET;
			sampling_q <= 1'b0;
			pending_q  <= 1'b0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			total_q    <= '0;
			err_q      <= '0;
			ovr_q      <= '0;
			last_q     <= '0;
		end else begin
			if (cfg_we) gain_q <= cfg_wdata;
			if (cmd.commit) begin
				sampling_q <= sampling_d;
				pending_q  <= pending_d;
				head_q     <= head_d;
				tail_q     <= tail_d;
				count_q    <= count_d;
				total_q    <= total_d;
				err_q      <= err_d;
				ovr_q      <= ovr_d;
				last_q     <= last_d;
			end
		end
	end

	// Output valid: set on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Load the result item
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_user_q <= {valid_rd, start_rd};
			m_data_q <= {3'b000, last_d, ovr_d, err_d, total_d, 5'(count_d), pop_word};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

// ===== rtl/core/ssc_checker.sv =====
// Port-level checker for the capture ring buffer, bound to the top level.
module ssc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [ssc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic [ssc_pkg::KIND_W-1:0]     s_axis_tuser,
	input logic                           cfg_we,
	input logic [ssc_pkg::GAIN_W-1:0]     cfg_wdata,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [ssc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [ssc_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import ssc_pkg::*;

	// Hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result item changed");

	// One item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again right after an accept");

	// A tick result never carries a popped sample
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("start_read and sample_valid both set");

	// Fill level never exceeds the ring depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[84:80] <= 5'(BUFFER_DEPTH)))
		else $error("fill level beyond ring depth");

endmodule

bind sensor_sample_capture_fifo_core ssc_checker u_ssc_checker (.*);
